[hdl/qp2p_pkg.sv]
// ----------------------------------------------------------------------------
// qp2p_pkg: shared types and constants for the quaternion pose projector
// Widths of the fixed-point datapath and the beat layouts used between units.
// ----------------------------------------------------------------------------
package qp2p_pkg;

  localparam int FIELD_W = 32;
  localparam int PROD_W  = 2 * FIELD_W;      // one 32x32 product
  localparam int NUM_W   = PROD_W + 2;       // numerator, signed, |num| <= 2^64
  localparam int DEN_W   = PROD_W + 1;       // squared norm, unsigned, <= 2^64
  localparam int QW      = FIELD_W;          // quotient bits
  localparam int REM_W   = DEN_W + QW;       // partial remainder
  localparam int DIV_LAT = QW + 2;           // prepare, one stage per bit, sign
  localparam int NENT    = 9;                // rotation entries
  localparam int IN_W    = 7 * FIELD_W;
  localparam int OUT_W   = 12 * FIELD_W;

  localparam logic signed [FIELD_W-1:0] ONE_Q30 = FIELD_W'(1 << 30);

  // Products of the quaternion components.
  typedef struct packed {
    logic signed [PROD_W-1:0] w2, x2, y2, z2, xy, wz, xz, wy, yz, wx;
  } prod_t;

  typedef logic [3*FIELD_W-1:0] trans_t;

endpackage

[hdl/qp2p_front.sv]
// ----------------------------------------------------------------------------
// qp2p_front: products and quadratic forms
// Stage one forms the ten component products, stage two the squared norm and
// the nine rotation numerators.
// ----------------------------------------------------------------------------
module qp2p_front import qp2p_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic [IN_W-1:0]                in_data,
  output logic                           out_valid,
  output logic [DEN_W-1:0]               n2_o,
  output logic signed [NUM_W-1:0]        num_o [NENT],
  output trans_t                         trans_o
);

  logic signed [FIELD_W-1:0] w, x, y, z;
  prod_t  prod_r, prod_nxt;
  trans_t trans1_r, trans2_r;
  logic   v1_r, v2_r;
  logic signed [NUM_W-1:0] e_w2, e_x2, e_y2, e_z2, e_xy, e_wz, e_xz, e_wy, e_yz, e_wx;
  logic signed [NUM_W-1:0] n2_full;
  logic signed [NUM_W-1:0] num_nxt [NENT];
  logic signed [NUM_W-1:0] num_r [NENT];
  logic [DEN_W-1:0] n2_r;

  assign w = $signed(in_data[0*FIELD_W +: FIELD_W]);
  assign x = $signed(in_data[1*FIELD_W +: FIELD_W]);
  assign y = $signed(in_data[2*FIELD_W +: FIELD_W]);
  assign z = $signed(in_data[3*FIELD_W +: FIELD_W]);

  // One multiplier per product, registered.
  always_comb begin
    prod_nxt.w2 = w * w;
    prod_nxt.x2 = x * x;
    prod_nxt.y2 = y * y;
    prod_nxt.z2 = z * z;
    prod_nxt.xy = x * y;
    prod_nxt.wz = w * z;
    prod_nxt.xz = x * z;
    prod_nxt.wy = w * y;
    prod_nxt.yz = y * z;
    prod_nxt.wx = w * x;
  end

  // Sign-extend to the numerator width and build the quadratic forms.
  always_comb begin
    e_w2 = NUM_W'(prod_r.w2);
    e_x2 = NUM_W'(prod_r.x2);
    e_y2 = NUM_W'(prod_r.y2);
    e_z2 = NUM_W'(prod_r.z2);
    e_xy = NUM_W'(prod_r.xy);
    e_wz = NUM_W'(prod_r.wz);
    e_xz = NUM_W'(prod_r.xz);
    e_wy = NUM_W'(prod_r.wy);
    e_yz = NUM_W'(prod_r.yz);
    e_wx = NUM_W'(prod_r.wx);
    n2_full    = e_w2 + e_x2 + e_y2 + e_z2;
    num_nxt[0] = e_w2 + e_x2 - e_y2 - e_z2;
    num_nxt[1] = (e_xy - e_wz) <<< 1;
    num_nxt[2] = (e_xz + e_wy) <<< 1;
    num_nxt[3] = (e_xy + e_wz) <<< 1;
    num_nxt[4] = e_w2 - e_x2 + e_y2 - e_z2;
    num_nxt[5] = (e_yz - e_wx) <<< 1;
    num_nxt[6] = (e_xz - e_wy) <<< 1;
    num_nxt[7] = (e_yz + e_wx) <<< 1;
    num_nxt[8] = e_w2 - e_x2 - e_y2 + e_z2;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r   <= prod_nxt;
      trans1_r <= in_data[4*FIELD_W +: 3*FIELD_W];
      trans2_r <= trans1_r;
      n2_r     <= n2_full[DEN_W-1:0];
      num_r    <= num_nxt;
    end
  end

  // Valid bits follow the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign n2_o      = n2_r;
  assign num_o     = num_r;
  assign trans_o   = trans2_r;

endmodule

[hdl/qp2p_div.sv]
// ----------------------------------------------------------------------------
// qp2p_div: pipelined rounding divider
// Computes round(num * 2^30 / den) with ties away from zero, one quotient
// bit per stage, then applies the sign.
// ----------------------------------------------------------------------------
module qp2p_div import qp2p_pkg::*; (
  input  logic                       clk,
  input  logic                       ce,
  input  logic signed [NUM_W-1:0]    num_i,
  input  logic [DEN_W-1:0]           den_i,
  output logic signed [FIELD_W-1:0]  q_o
);

  logic [REM_W-1:0] rem_r [QW+1];
  logic [DEN_W-1:0] den_r [QW+1];
  logic             neg_r [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic [NUM_W-1:0] mag_full;
  logic signed [FIELD_W:0] sq;
  logic signed [FIELD_W-1:0] q_out_r, q_nxt;

  assign mag_full = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // Prepare stage: remainder starts at 2*mag*2^30 plus den for rounding.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= (REM_W'(mag_full[DEN_W-1:0]) << (QW - 1)) + REM_W'(den_i);
      den_r[0] <= den_i;
      neg_r[0] <= num_i[NUM_W-1];
      q_r[0]   <= '0;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int Bit = QW - 1 - s;
    logic [REM_W-1:0] d;
    logic             take;
    assign d    = REM_W'(den_r[s]) << (Bit + 1);
    assign take = rem_r[s] >= d;
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s+1] <= take ? rem_r[s] - d : rem_r[s];
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
        q_r[s+1]   <= q_r[s] | (take ? QW'(1) << Bit : '0);
      end
    end
  end

  // Apply the sign with saturation to the signed 32-bit range.
  always_comb begin
    sq = neg_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
    if (!neg_r[QW] && q_r[QW][QW-1]) begin
      q_nxt = {1'b0, {(FIELD_W-1){1'b1}}};
    end else if (neg_r[QW] && q_r[QW] > {1'b1, {(QW-1){1'b0}}}) begin
      q_nxt = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      q_nxt = sq[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      q_out_r <= q_nxt;
    end
  end

  assign q_o = q_out_r;

endmodule

[hdl/qp2p_skid.sv]
// ----------------------------------------------------------------------------
// qp2p_skid: output register with skid stage
// Holds a finished beat for the consumer and catches one more from the
// pipeline, so the pipeline enable comes straight from a register.
// ----------------------------------------------------------------------------
module qp2p_skid import qp2p_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [OUT_W-1:0] in_data,
  output logic             in_ready,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data,
  input  logic             out_ready
);

  logic             out_v_r, skid_v_r;
  logic [OUT_W-1:0] out_d_r, skid_d_r;

  // Control: output slot refills from the skid first, then from the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      out_v_r  <= skid_v_r || in_valid;
      skid_v_r <= 1'b0;
    end else if (in_valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      out_d_r <= skid_v_r ? skid_d_r : in_data;
    end else if (in_valid && !skid_v_r) begin
      skid_d_r <= in_data;
    end
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

[hdl/quaternion_pose_to_projection.sv]
// ----------------------------------------------------------------------------
// quaternion_pose_to_projection: camera pose to 3x4 projection matrix [R|t]
// Normalized quaternion rotation matrix in Q2.30 with translation passed on.
// ----------------------------------------------------------------------------
// The block accepts one pose beat per clock while in_tready is high and
// returns one matrix beat per pose, in order. An accepted input beat passes
// through the component products and quadratic forms, the nine pipelined
// dividers (one quotient bit per stage) and the output register. A stalled
// output holds its beat while one more beat drains into a skid register; the
// input is then held off until it clears.
// A zero quaternion yields the identity rotation.
module quaternion_pose_to_projection import qp2p_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z (32 bits each)
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // rot_00 .. rot_22 row-major, proj_tx, proj_ty, proj_tz (32 bits each)
  output logic [OUT_W-1:0] out_tdata
);

  logic                      ce;
  logic                      fr_valid;
  logic [DEN_W-1:0]          fr_n2;
  logic signed [NUM_W-1:0]   fr_num [NENT];
  trans_t                    fr_trans;
  logic signed [FIELD_W-1:0] q [NENT];
  logic                      v_r     [DIV_LAT];
  logic                      zero_r  [DIV_LAT];
  trans_t                    trans_r [DIV_LAT];
  logic [OUT_W-1:0]          res;

  // The whole pipeline advances while the skid register is free.
  assign ce = in_tready;

  qp2p_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_tvalid),
    .in_data   (in_tdata),
    .out_valid (fr_valid),
    .n2_o      (fr_n2),
    .num_o     (fr_num),
    .trans_o   (fr_trans)
  );

  for (genvar k = 0; k < NENT; k++) begin : g_div
    qp2p_div u_div (
      .clk   (clk),
      .ce    (ce),
      .num_i (fr_num[k]),
      .den_i (fr_n2),
      .q_o   (q[k])
    );
  end

  // Side line carrying valid, zero flag and translation beside the dividers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) v_r[i] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= fr_valid;
      for (int i = 1; i < DIV_LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zero_r[0]  <= (fr_n2 == '0);
      trans_r[0] <= fr_trans;
      for (int i = 1; i < DIV_LAT; i++) begin
        zero_r[i]  <= zero_r[i-1];
        trans_r[i] <= trans_r[i-1];
      end
    end
  end

  // Assemble the output beat; a zero quaternion gives the identity.
  always_comb begin
    for (int k = 0; k < NENT; k++) begin
      if (zero_r[DIV_LAT-1]) begin
        res[k*FIELD_W +: FIELD_W] = (k % 4 == 0) ? ONE_Q30 : '0;
      end else begin
        res[k*FIELD_W +: FIELD_W] = q[k];
      end
    end
    res[NENT*FIELD_W +: 3*FIELD_W] = trans_r[DIV_LAT-1];
  end

  qp2p_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[DIV_LAT-1]),
    .in_data   (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_ready (out_tready)
  );

endmodule

[hdl/qp2p_checker.sv]
// ----------------------------------------------------------------------------
// qp2p_checker: port-level checks for the pose projector
// Watches the stream ports for hold, stall and range behavior.
// ----------------------------------------------------------------------------
module qp2p_checker import qp2p_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled output beat stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  // The input is held off only while an output beat is waiting.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no output pending");

  // No output beat in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output valid right after reset");

  // The first rotation entry stays within plus or minus one.
  a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[FIELD_W-1:0]) <= ONE_Q30 &&
                    $signed(out_tdata[FIELD_W-1:0]) >= -ONE_Q30))
    else $error("rotation entry out of range");

endmodule

bind quaternion_pose_to_projection qp2p_checker u_qp2p_checker (.*);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for quaternion_pose_to_projection
// Drives pose beats with random gaps, stalls the output at random and checks
// every matrix beat against a fixed-point model of the normalized rotation.
// ----------------------------------------------------------------------------
module tb;
  import qp2p_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int LATENCY    = 37;
  localparam int CYCLE_CAP  = 400000;
  localparam int NUM_DIRECTED = 14;

  typedef logic [31:0] word_t;
  typedef logic signed [127:0] wide_t;

  // One directed row: pose, flag for a typed-in rotation, and that rotation.
  typedef struct {
    word_t qw, qx, qy, qz, tx, ty, tz;
    bit    has_rot;
    word_t rot [9];
  } pose_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  logic [OUT_W-1:0] matrix_queue [$];
  int  cycle_count;
  bit  failed;
  bit  quiet_phase;
  int  out_stall_left;

  quaternion_pose_to_projection DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded num/den in Q2.30, ties away from zero, saturated.
  function automatic word_t ratio_to_q30(wide_t num, wide_t den);
    wide_t mag;
    wide_t q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< 31) + den) / (den <<< 1);
    if (num < 0) begin
      if (q > 128'sh80000000) q = 128'sh80000000;
      return word_t'(-q);
    end
    if (q > 128'sh7FFFFFFF) q = 128'sh7FFFFFFF;
    return word_t'(q);
  endfunction

  // Expected matrix beat for one pose beat.
  function automatic logic [OUT_W-1:0] pose_matrix(logic [IN_W-1:0] pose);
    wide_t w, x, y, z, n2;
    wide_t w2, x2, y2, z2, xy, wz, xz, wy, yz, wx;
    wide_t num [9];
    logic [OUT_W-1:0] res;
    w = $signed(pose[31:0]);
    x = $signed(pose[63:32]);
    y = $signed(pose[95:64]);
    z = $signed(pose[127:96]);
    w2 = w * w; x2 = x * x; y2 = y * y; z2 = z * z;
    xy = x * y; wz = w * z; xz = x * z; wy = w * y; yz = y * z; wx = w * x;
    n2 = w2 + x2 + y2 + z2;
    num[0] = w2 + x2 - y2 - z2;
    num[1] = 2 * (xy - wz);
    num[2] = 2 * (xz + wy);
    num[3] = 2 * (xy + wz);
    num[4] = w2 - x2 + y2 - z2;
    num[5] = 2 * (yz - wx);
    num[6] = 2 * (xz - wy);
    num[7] = 2 * (yz + wx);
    num[8] = w2 - x2 - y2 + z2;
    for (int k = 0; k < 9; k++) begin
      if (n2 == 0) res[32*k +: 32] = (k % 4 == 0) ? ONE_Q30 : '0;
      else res[32*k +: 32] = ratio_to_q30(num[k], n2);
    end
    res[OUT_W-1 -: 96] = pose[IN_W-1 -: 96];
    return res;
  endfunction

  function automatic logic [IN_W-1:0] pack_pose(word_t qw, word_t qx, word_t qy,
                                                word_t qz, word_t tx, word_t ty,
                                                word_t tz);
    return {tz, ty, tx, qz, qy, qx, qw};
  endfunction

  // Random component: full range, small magnitudes, or edge values.
  function automatic word_t rand_component();
    case ($urandom_range(0, 5))
      0: return word_t'(32'h8000_0000 + $urandom_range(0, 3));
      1: return word_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
      2: return word_t'($signed($urandom_range(0, 8)) - 4);
      3: return word_t'($signed($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
      default: return $urandom();
    endcase
  endfunction

  // Send one pose beat, idling at random beforehand.
  task automatic send_pose(logic [IN_W-1:0] pose);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pose;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    matrix_queue.push_back(pose_matrix(pose));
  endtask

  // Output stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      out_stall_left <= 0;
    end else if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_tready <= (out_stall_left == 1);
    end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      out_stall_left <= $urandom_range(1, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted matrix beat with the oldest expectation.
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_queue.size() == 0) begin
        $error("matrix beat with no pose pending: %h", out_tdata);
        failed = 1'b1;
      end else begin
        want = matrix_queue.pop_front();
        for (int k = 0; k < 12; k++) begin
          if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
            if (k < 9)
              $error("rot_%0d%0d expected %h actual %h", k / 3, k % 3,
                     want[32*k +: 32], out_tdata[32*k +: 32]);
            else
              $error("proj_t%s expected %h actual %h", (k == 9) ? "x" :
                     (k == 10) ? "y" : "z", want[32*k +: 32], out_tdata[32*k +: 32]);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("quaternion_pose_to_projection test failed");
      $finish;
    end
  end

  initial begin
    pose_row_t rows [NUM_DIRECTED];
    logic [IN_W-1:0] pose;
    logic [OUT_W-1:0] typed;
    int drain;
    cycle_count = 0;
    failed = 1'b0;
    quiet_phase = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;

    // Directed rows. Typed rotations: identity cases and axis extremes.
    rows[0]  = '{0, 0, 0, 0, 0, 0, 0, 1, '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30}};
    rows[1]  = '{0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                 '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30}};
    rows[2]  = '{32'h1000_0000, 0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_0000, 1,
                 '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30}};
    rows[3]  = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                 '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30}};
    rows[4]  = '{0, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                 '{ONE_Q30, 0, 0, 0, -ONE_Q30, 0, 0, 0, -ONE_Q30}};
    rows[5]  = '{0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1,
                 '{-ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, -ONE_Q30}};
    rows[6]  = '{0, 0, 0, 1, 0, 0, 0, 1,
                 '{-ONE_Q30, 0, 0, 0, -ONE_Q30, 0, 0, 0, ONE_Q30}};
    rows[7]  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 2, 3, 0, '{default: 0}};
    rows[8]  = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0,
                 '{default: 0}};
    rows[9]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0,
                 '{default: 0}};
    rows[10] = '{1, 1, 0, 0, 0, 0, 0, 0, '{default: 0}};
    rows[11] = '{1, 2, 3, 32'hFFFF_FFFC, 5, 6, 7, 0, '{default: 0}};
    rows[12] = '{32'hFFFF_FFFF, 0, 0, 1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hDEAD_BEEF, 0,
                 '{default: 0}};
    rows[13] = '{32'h0B50_F4F0, 32'h0B50_F4F0, 0, 0, 0, 0, 0, 0, '{default: 0}};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the model's rotation is checked against each typed rotation.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      pose = pack_pose(rows[r].qw, rows[r].qx, rows[r].qy, rows[r].qz,
                       rows[r].tx, rows[r].ty, rows[r].tz);
      if (rows[r].has_rot) begin
        typed = pose_matrix(pose);
        for (int k = 0; k < 9; k++) begin
          if (typed[32*k +: 32] !== rows[r].rot[k]) begin
            $error("table rot_%0d%0d expected %h actual %h", k / 3, k % 3,
                   rows[r].rot[k], typed[32*k +: 32]);
            failed = 1'b1;
          end
        end
      end
      send_pose(pose);
    end

    // Random poses; the last part runs without idling.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - 300) quiet_phase = 1'b1;
      send_pose(pack_pose(rand_component(), rand_component(), rand_component(),
                          rand_component(), $urandom(), $urandom(), $urandom()));
    end
    in_tvalid <= 1'b0;

    while (matrix_queue.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < LATENCY + 10) begin
      @(posedge clk);
      drain++;
    end

    if (!failed)
      $display("quaternion_pose_to_projection test passed");
    else
      $display("quaternion_pose_to_projection test failed");
    $finish;
  end

endmodule

[files.f]
hdl/qp2p_pkg.sv
hdl/qp2p_front.sv
hdl/qp2p_div.sv
hdl/qp2p_skid.sv
hdl/quaternion_pose_to_projection.sv
hdl/qp2p_checker.sv
dv/tb.sv
